FILE: sv/evio_bank_endian_swapper_core_defines.svh
// Assertion macros shared by the event-format swapper RTL.
// Expects clk and rst_n in the scope of each use.
`ifndef EVIO_BANK_ENDIAN_SWAPPER_CORE_DEFINES_SVH
`define EVIO_BANK_ENDIAN_SWAPPER_CORE_DEFINES_SVH

// same-cycle implication
`define EVB_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("evb assertion failed (same cycle)");

// next-cycle implication
`define EVB_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("evb assertion failed (next cycle)");

`endif

FILE: sv/evb_pkg.sv
// Shared types and constants for the event-format bank swapper.
// No dependencies.
package evb_pkg;

  localparam int WORD_W = 32;
  localparam int POS_W  = 21;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_SHORT_BUF    = 3'd1,
    ST_BANK_OVERRUN = 3'd2,
    ST_ZERO_LEN     = 3'd3,
    ST_BAD_TYPE     = 3'd4,
    ST_SEG_OVERRUN  = 3'd5
  } status_t;

  typedef struct packed {
    logic [WORD_W-1:0] data_word;
    logic              first_word;
    logic [POS_W-1:0]  buffer_words;
  } item_t;

  typedef struct packed {
    logic [WORD_W-1:0] swapped_word;
    status_t           status;
    logic              last_result;
    logic [POS_W-1:0]  words_done;
  } result_t;

  // results produced by one transaction: count is 0, 1 or 2, r0 goes out first
  typedef struct packed {
    logic [1:0] count;
    result_t    r0;
    result_t    r1;
  } push_t;

endpackage

FILE: sv/evb_if.sv
// Valid/ready stream interfaces for the swapper's input and result channels.
// Depends on evb_pkg.
interface evb_in_if import evb_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] data_word;
  logic              first_word;
  logic [POS_W-1:0]  buffer_words;

  modport source (output valid, data_word, first_word, buffer_words, input ready);
  modport sink   (input valid, data_word, first_word, buffer_words, output ready);
endinterface

interface evb_out_if import evb_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] swapped_word;
  logic [2:0]        status;
  logic              last_result;
  logic [POS_W-1:0]  words_done;

  modport source (output valid, swapped_word, status, last_result, words_done, input ready);
  modport sink   (input valid, swapped_word, status, last_result, words_done, output ready);
endinterface

FILE: sv/evio_bank_endian_swapper_core.sv
// Top level of the event-format bank byte-order swapper.
// Depends on evb_pkg, evb_if, evb_parser and evb_out_queue.
//
//   channel  | dir | handshake        | payload
//   in_ch    | in  | valid / ready    | data_word, first_word, buffer_words
//   out_ch   | out | valid / ready    | swapped_word, status, last_result, words_done
//
// One word per cycle while in_ch.ready is high: input register -> parser ->
// four-entry result queue. The second word of a 64-bit pair yields two results,
// drained one per cycle while out_ch.ready is high.
// in_ch.ready drops only while a word waits and the queue holds more than two results.
// rst_n (synchronous) idles the parser until a word with first_word arrives.
module evio_bank_endian_swapper_core import evb_pkg::*; #(
  parameter int MAX_NEST_DEPTH   = 8,
  parameter int MAX_BUFFER_WORDS = 1048576
) (
  input logic clk,
  input logic rst_n,
  evb_in_if.sink    in_ch,
  evb_out_if.source out_ch
);

  item_t item_r;
  logic  item_vld_r, item_vld_nxt;
  logic  room, go, take;
  push_t push;

  assign go          = item_vld_r && room;
  assign in_ch.ready = !item_vld_r || room;
  assign take        = in_ch.valid && in_ch.ready;

  always_comb begin
    item_vld_nxt = item_vld_r;
    if (take)    item_vld_nxt = 1'b1;
    else if (go) item_vld_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) item_vld_r <= 1'b0;
    else        item_vld_r <= item_vld_nxt;
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_r.data_word    <= in_ch.data_word;
      item_r.first_word   <= in_ch.first_word;
      item_r.buffer_words <= in_ch.buffer_words;
    end
  end

  evb_parser #(
    .MAX_NEST_DEPTH   (MAX_NEST_DEPTH),
    .MAX_BUFFER_WORDS (MAX_BUFFER_WORDS)
  ) u_parser (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (go),
    .item  (item_r),
    .push  (push)
  );

  evb_out_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .room   (room),
    .out_ch (out_ch)
  );

endmodule

FILE: sv/evb_parser.sv
// Header/payload parser: nesting stack, byte reordering and error checks.
// Depends on evb_pkg and the assertion macro header.
`include "evio_bank_endian_swapper_core_defines.svh"

module evb_parser import evb_pkg::*; #(
  parameter int MAX_NEST_DEPTH   = 8,
  parameter int MAX_BUFFER_WORDS = 1048576
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  go,
  input  item_t item,
  output push_t push
);

  localparam int LVL_W = $clog2(MAX_NEST_DEPTH + 1);
  localparam int IDX_W = (MAX_NEST_DEPTH > 1) ? $clog2(MAX_NEST_DEPTH) : 1;
  localparam logic [31:0]      MAX_BUF = 32'(MAX_BUFFER_WORDS);
  localparam logic [LVL_W-1:0] LVL_MAX = LVL_W'(MAX_NEST_DEPTH);

  typedef enum logic [3:0] {
    PH_IDLE, PH_HDR, PH_BANK2, PH_P64, PH_P32, PH_P16, PH_RAW
  } phase_t;

  typedef enum logic [1:0] {
    KIND_BANK, KIND_SEG, KIND_TAG
  } kind_t;

  function automatic logic [WORD_W-1:0] bsw32(logic [WORD_W-1:0] w);
    return {w[7:0], w[15:8], w[23:16], w[31:24]};
  endfunction

  function automatic logic [WORD_W-1:0] bsw16(logic [WORD_W-1:0] w);
    return {w[23:16], w[31:24], w[7:0], w[15:8]};
  endfunction

  function automatic phase_t data_phase(logic [7:0] t);
    phase_t p;
    case (t)
      8'h0a, 8'h08, 8'h09: p = PH_P64;
      8'h01, 8'h02, 8'h0b: p = PH_P32;
      8'h05, 8'h04:        p = PH_P16;
      8'h00, 8'h07, 8'h06: p = PH_RAW;
      default:             p = PH_IDLE;
    endcase
    return p;
  endfunction

  function automatic result_t mk(logic [WORD_W-1:0] w, status_t st, logic last,
                                 logic [POS_W-1:0] pos);
    result_t r;
    r.swapped_word = w;
    r.status       = st;
    r.last_result  = last;
    r.words_done   = last ? pos : '0;
    return r;
  endfunction

  // state
  phase_t            phase_r, phase_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [LVL_W-1:0]  lvl_r, lvl_nxt;
  logic              pend_r, pend_nxt;
  logic [POS_W-1:0]  pe_r, pe_nxt;
  logic [WORD_W-1:0] held_r, held_nxt;
  logic [POS_W-1:0]  end_r  [MAX_NEST_DEPTH];
  kind_t             kind_r [MAX_NEST_DEPTH];

  // working values
  phase_t            ph_e, dph;
  logic [POS_W-1:0]  pos_e, pos_n, pe_e, lim, avail, e_top;
  logic [LVL_W-1:0]  lvl_e, close_lvl;
  logic              pend_e, close_done, top_lvl, stk_push, at_end;
  logic [IDX_W-1:0]  top_idx, push_idx;
  logic [31:0]       bw32, lim32;
  logic [WORD_W-1:0] w, sw;
  logic [15:0]       seg_n;
  logic [7:0]        t;
  kind_t             hdr_kind, push_kind;
  push_t             push_c;
  logic              last_out;

  always_comb begin
    w = item.data_word;
    pos_e  = pos_r;
    lvl_e  = lvl_r;
    ph_e   = phase_r;
    pend_e = pend_r;
    pe_e   = pe_r;
    if (item.first_word) begin
      pos_e  = '0;
      lvl_e  = '0;
      ph_e   = PH_HDR;
      pend_e = 1'b0;
      pe_e   = '0;
    end
    pos_n  = pos_e + POS_W'(1);
    at_end = (pos_n == pe_e);
    sw     = bsw32(w);

    // keep every level up to the highest whose end is not reached; pop the ones above it
    close_lvl = '0;
    for (int j = 0; j < MAX_NEST_DEPTH; j++) begin
      if ((LVL_W'(j) < lvl_e) && (end_r[j] != pos_n)) close_lvl = LVL_W'(j + 1);
    end
    close_done = (close_lvl == '0);

    top_lvl  = (lvl_e == '0);
    top_idx  = IDX_W'(lvl_e - LVL_W'(1));
    push_idx = IDX_W'(lvl_e);
    e_top    = end_r[top_idx];
    hdr_kind = top_lvl ? KIND_BANK : kind_r[top_idx];
    bw32     = {11'b0, item.buffer_words};
    lim32    = (bw32 > MAX_BUF) ? MAX_BUF : bw32;
    lim      = lim32[POS_W-1:0];
    if (top_lvl) avail = (lim > pos_e) ? (lim - pos_e) : '0;
    else         avail = (e_top > pos_e) ? (e_top - pos_e) : '0;

    seg_n = sw[15:0];
    t = (hdr_kind == KIND_SEG) ? {2'b00, sw[21:16]} : {4'b0000, sw[19:16]};
    dph = data_phase(t);

    phase_nxt = ph_e;
    pos_nxt   = pos_e;
    lvl_nxt   = lvl_e;
    pend_nxt  = pend_e;
    pe_nxt    = pe_e;
    held_nxt  = held_r;
    stk_push  = 1'b0;
    push_kind = KIND_BANK;
    push_c    = '0;

    if (ph_e != PH_IDLE) begin
      pos_nxt = pos_n;
      case (ph_e)
        PH_HDR: begin
          if (hdr_kind == KIND_BANK) begin
            if (avail < POS_W'(2)) begin
              phase_nxt = PH_IDLE; pend_nxt = 1'b0;
              push_c.count = 2'd1; push_c.r0 = mk(sw, ST_SHORT_BUF, 1'b1, pos_n);
            end else if (({1'b0, sw} + 33'd1) > {12'b0, avail}) begin
              phase_nxt = PH_IDLE; pend_nxt = 1'b0;
              push_c.count = 2'd1; push_c.r0 = mk(sw, ST_BANK_OVERRUN, 1'b1, pos_n);
            end else if (sw == '0) begin
              phase_nxt = PH_IDLE; pend_nxt = 1'b0;
              push_c.count = 2'd1; push_c.r0 = mk(sw, ST_ZERO_LEN, 1'b1, pos_n);
            end else begin
              pe_nxt    = pos_n + sw[POS_W-1:0];
              phase_nxt = PH_BANK2;
              push_c.count = 2'd1; push_c.r0 = mk(sw, ST_OK, 1'b0, pos_n);
            end
          end else begin
            if ((22'(seg_n) + 22'd1) > {1'b0, avail}) begin
              phase_nxt = PH_IDLE; pend_nxt = 1'b0;
              push_c.count = 2'd1; push_c.r0 = mk(sw, ST_SEG_OVERRUN, 1'b1, pos_n);
            end else if (dph != PH_IDLE && seg_n != '0) begin
              pe_nxt    = pos_n + POS_W'(seg_n);
              phase_nxt = dph;
              push_c.count = 2'd1; push_c.r0 = mk(sw, ST_OK, 1'b0, pos_n);
            end else begin
              // container-typed, unknown-typed or empty segment: header only
              lvl_nxt   = close_lvl;
              phase_nxt = close_done ? PH_IDLE : PH_HDR;
              push_c.count = 2'd1; push_c.r0 = mk(sw, ST_OK, close_done, pos_n);
            end
          end
        end
        PH_BANK2: begin
          logic bad;
          bad = 1'b0;
          if (data_phase(sw[15:8]) == PH_IDLE) begin
            case (sw[15:8])
              8'h0c:        push_kind = KIND_TAG;
              8'h0d, 8'h20: push_kind = KIND_SEG;
              8'h0e, 8'h10: push_kind = KIND_BANK;
              default:      bad = 1'b1;
            endcase
          end
          if (bad) begin
            phase_nxt = PH_IDLE; pend_nxt = 1'b0;
            push_c.count = 2'd1; push_c.r0 = mk(sw, ST_BAD_TYPE, 1'b1, pos_n);
          end else if (at_end) begin
            lvl_nxt   = close_lvl;
            phase_nxt = close_done ? PH_IDLE : PH_HDR;
            push_c.count = 2'd1; push_c.r0 = mk(sw, ST_OK, close_done, pos_n);
          end else if (data_phase(sw[15:8]) != PH_IDLE) begin
            phase_nxt = data_phase(sw[15:8]);
            push_c.count = 2'd1; push_c.r0 = mk(sw, ST_OK, 1'b0, pos_n);
          end else if (lvl_e >= LVL_MAX) begin
            // nesting too deep
            phase_nxt = PH_IDLE; pend_nxt = 1'b0;
            push_c.count = 2'd1; push_c.r0 = mk(sw, ST_BAD_TYPE, 1'b1, pos_n);
          end else begin
            stk_push  = 1'b1;
            lvl_nxt   = lvl_e + LVL_W'(1);
            phase_nxt = PH_HDR;
            push_c.count = 2'd1; push_c.r0 = mk(sw, ST_OK, 1'b0, pos_n);
          end
        end
        PH_P64: begin
          if (!pend_e) begin
            if (at_end) begin
              // odd trailing word passes unchanged
              lvl_nxt   = close_lvl;
              phase_nxt = close_done ? PH_IDLE : PH_HDR;
              push_c.count = 2'd1; push_c.r0 = mk(w, ST_OK, close_done, pos_n);
            end else begin
              held_nxt = w;
              pend_nxt = 1'b1;
            end
          end else begin
            pend_nxt = 1'b0;
            push_c.count = 2'd2;
            push_c.r0 = mk(sw, ST_OK, 1'b0, pos_n);
            push_c.r1 = mk(bsw32(held_r), ST_OK, 1'b0, pos_n);
            if (at_end) begin
              lvl_nxt   = close_lvl;
              phase_nxt = close_done ? PH_IDLE : PH_HDR;
              push_c.r1 = mk(bsw32(held_r), ST_OK, close_done, pos_n);
            end
          end
        end
        PH_P32, PH_P16, PH_RAW: begin
          logic [WORD_W-1:0] o;
          o = (ph_e == PH_P32) ? sw : ((ph_e == PH_P16) ? bsw16(w) : w);
          push_c.count = 2'd1;
          push_c.r0 = mk(o, ST_OK, 1'b0, pos_n);
          if (at_end) begin
            lvl_nxt   = close_lvl;
            phase_nxt = close_done ? PH_IDLE : PH_HDR;
            push_c.r0 = mk(o, ST_OK, close_done, pos_n);
          end
        end
        default: begin
          phase_nxt = PH_IDLE;
          pos_nxt   = pos_e;
        end
      endcase
    end

    push = push_c;
    if (!go) push.count = 2'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      pos_r   <= '0;
      lvl_r   <= '0;
      pend_r  <= 1'b0;
      pe_r    <= '0;
    end else if (go) begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      lvl_r   <= lvl_nxt;
      pend_r  <= pend_nxt;
      pe_r    <= pe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      held_r <= held_nxt;
      if (stk_push) begin
        end_r[push_idx]  <= pe_e;
        kind_r[push_idx] <= push_kind;
      end
    end
  end

  assign last_out = (push.count != 2'd0) &&
                    ((push.count == 2'd1 && push.r0.last_result) ||
                     (push.count == 2'd2 && push.r1.last_result));

  `EVB_ASSERT_NXT(a_idle_after_last, last_out, phase_r == PH_IDLE)
  `EVB_ASSERT_IMP(a_pair_in_p64, pend_r, phase_r == PH_P64)
  `EVB_ASSERT_IMP(a_lvl_bound, 1'b1, lvl_r <= LVL_MAX)

endmodule

FILE: sv/evb_out_queue.sv
// Four-entry result queue: takes up to two results a cycle, hands out one on out_ch.ready.
// Depends on evb_pkg, evb_if and the assertion macro header.
`include "evio_bank_endian_swapper_core_defines.svh"

module evb_out_queue import evb_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  push_t push,
  output logic  room,
  evb_out_if.source out_ch
);

  localparam int DEPTH = 4;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  result_t          q_mem [DEPTH];
  logic [PTR_W-1:0] rd_r, rd_nxt, wr_r, wr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             pop;
  result_t          head;

  assign head = q_mem[rd_r];
  assign pop  = out_ch.valid && out_ch.ready;
  // room for a two-result transaction
  assign room = (cnt_r <= CNT_W'(DEPTH - 2));

  assign out_ch.valid        = (cnt_r != '0);
  assign out_ch.swapped_word = head.swapped_word;
  assign out_ch.status       = head.status;
  assign out_ch.last_result  = head.last_result;
  assign out_ch.words_done   = head.words_done;

  always_comb begin
    wr_nxt  = wr_r + PTR_W'(push.count);
    rd_nxt  = rd_r + PTR_W'(pop);
    cnt_nxt = cnt_r + CNT_W'(push.count) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_r  <= '0;
      wr_r  <= '0;
      cnt_r <= '0;
    end else begin
      rd_r  <= rd_nxt;
      wr_r  <= wr_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) q_mem[wr_r] <= push.r0;
    if (push.count == 2'd2) q_mem[wr_r + PTR_W'(1)] <= push.r1;
  end

  `EVB_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_r <= CNT_W'(DEPTH))
  `EVB_ASSERT_IMP(a_push_room, push.count != 2'd0, cnt_r <= CNT_W'(DEPTH - 2))

endmodule
